/* hw/rtl/hlpi_pkg.sv */
package hlpi_pkg;

    // Angle grid and field widths
    localparam int ANGLE_STEPS = 360;
    localparam int QUARTER     = ANGLE_STEPS / 2;
    localparam int TRIG_AW     = $clog2(QUARTER);
    localparam int ANGLE_W     = 9;
    localparam int RHO_W       = 16;
    localparam int TRIG_W      = 16;
    localparam int TRIG_MAG_W  = 15;
    localparam int PROD_W      = 32;
    localparam int MAG_W       = 31;
    localparam int NUM_W       = 47;
    localparam int QUO_W       = 24;
    localparam int OUT_W       = 24;
    localparam int THR_W       = 31;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;

    localparam logic [THR_W-1:0] THR_RESET = 31'd10737;
    localparam logic             REG_DET_THRESHOLD = 1'b0;

    localparam logic signed [OUT_W-1:0] OUT_MAX = 24'sh7FFFFF;
    localparam logic signed [OUT_W-1:0] OUT_MIN = 24'sh800000;

    // Quadrant codes of an angle index
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    // Fixed-point constants of the series evaluation
    localparam longint unsigned PI_Q30  = 64'd3373259426;
    localparam longint          ONE_Q30 = 64'sd1073741824;
    localparam int              TAYLOR_TERMS = 8;

    // Series divisors: (2k)(2k+1) for sine, (2k-1)(2k) for cosine
    localparam longint unsigned SIN_DIV [1:TAYLOR_TERMS] =
        '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272};
    localparam longint unsigned COS_DIV [1:TAYLOR_TERMS] =
        '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182, 64'd240};

    typedef struct packed {
        logic signed [RHO_W-1:0] first_rho;
        logic [ANGLE_W-1:0]      first_angle;
        logic signed [RHO_W-1:0] second_rho;
        logic [ANGLE_W-1:0]      second_angle;
    } req_t;

    typedef struct packed {
        logic                    valid_res;
        logic signed [OUT_W-1:0] point_x;
        logic signed [OUT_W-1:0] point_y;
    } res_t;

    // One entry: {sine, cosine} of the first quadrant, Q0.15 magnitudes
    typedef logic [2*TRIG_MAG_W-1:0] trig_entry_t;
    typedef trig_entry_t trig_rom_t [QUARTER];

    function automatic logic [TRIG_MAG_W-1:0] q30_to_q15(longint v);
        longint w;
        longint r;
        w = v;
        if (w < 0)
            w = 0;
        if (w > ONE_Q30)
            w = ONE_Q30;
        r = (w + 16384) >>> 15;
        if (r > 32767)
            r = 32767;
        return r[TRIG_MAG_W-1:0];
    endfunction

    // Build the quarter-wave table from the integer Taylor series
    function automatic trig_rom_t build_trig_rom();
        trig_rom_t         rom;
        longint unsigned   x;
        longint unsigned   x2;
        longint unsigned   term;
        longint            sacc;
        longint            cacc;
        for (int j = 0; j < QUARTER; j++) begin
            x  = (longint'(j) * PI_Q30) / ANGLE_STEPS;
            x2 = (x * x) >> 30;
            term = x;
            sacc = longint'(x);
            for (int k = 1; k <= TAYLOR_TERMS; k++) begin
                term = ((term * x2) >> 30) / SIN_DIV[k];
                sacc = (k % 2 == 1) ? sacc - longint'(term) : sacc + longint'(term);
            end
            term = longint'(ONE_Q30);
            cacc = ONE_Q30;
            for (int k = 1; k <= TAYLOR_TERMS; k++) begin
                term = ((term * x2) >> 30) / COS_DIV[k];
                cacc = (k % 2 == 1) ? cacc - longint'(term) : cacc + longint'(term);
            end
            rom[j] = {q30_to_q15(sacc), q30_to_q15(cacc)};
        end
        return rom;
    endfunction

    localparam trig_rom_t TRIG_ROM = build_trig_rom();

endpackage

/* hw/rtl/hough_line_pair_intersection_unit.sv */
// Hough line pair intersection: one request per clock, no back-pressure.
// A request is taken whenever start is high (busy is always low) and its
// result is shown on result with done high, in order, and is taken at the
// edge that ends that cycle. A request passes through the trig lookup, the
// multiply and difference stages, the magnitude and threshold stage, the
// dividend set-up, a 24-stage pipelined long divider for each coordinate
// and the output register; the receiver must take every result in the
// cycle it is shown. Parallel pairs and pairs with |det| below det_threshold
// give valid_res low and a zero point. det_threshold is written over APB at 0x0.
module hough_line_pair_intersection_unit
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  hlpi_pkg::req_t                request,
    output logic                          done,
    output hlpi_pkg::res_t                result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [hlpi_pkg::PADDR_W-1:0]  paddr,
    input  logic [hlpi_pkg::PDATA_W-1:0]  pwdata,
    output logic [hlpi_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    localparam int NST   = hlpi_pkg::QUO_W;
    localparam int NUM_W = hlpi_pkg::NUM_W;
    localparam int HI_W  = NUM_W - NST;

    // ---------------- configuration ----------------
    logic [hlpi_pkg::THR_W-1:0] thr_reg;
    logic                       thr_sel;

    assign thr_sel = (paddr[hlpi_pkg::PADDR_W-1] == hlpi_pkg::REG_DET_THRESHOLD);
    assign pready  = 1'b1;
    assign busy    = 1'b0;

    // Write the threshold on the access cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= hlpi_pkg::THR_RESET;
        end
        else if (psel && penable && pwrite && thr_sel)
        begin
            thr_reg <= pwdata[hlpi_pkg::THR_W-1:0];
        end
    end

    assign prdata = thr_sel ? {1'b0, thr_reg} : '0;

    // ---------------- stage 1: trig lookup ----------------
    function automatic logic [2*hlpi_pkg::TRIG_W-1:0] trig_lookup(
        logic [hlpi_pkg::ANGLE_W-1:0] a);
        logic [1:0]                        q;
        logic [hlpi_pkg::ANGLE_W:0]        r;
        hlpi_pkg::trig_entry_t             e;
        logic signed [hlpi_pkg::TRIG_W-1:0] s;
        logic signed [hlpi_pkg::TRIG_W-1:0] c;
        logic signed [hlpi_pkg::TRIG_W-1:0] so;
        logic signed [hlpi_pkg::TRIG_W-1:0] co;
        if (int'(a) >= 3 * hlpi_pkg::QUARTER)
        begin
            q = hlpi_pkg::QUAD_3;
            r = {1'b0, a} - 10'(3 * hlpi_pkg::QUARTER);
        end
        else if (int'(a) >= 2 * hlpi_pkg::QUARTER)
        begin
            q = hlpi_pkg::QUAD_2;
            r = {1'b0, a} - 10'(2 * hlpi_pkg::QUARTER);
        end
        else if (int'(a) >= hlpi_pkg::QUARTER)
        begin
            q = hlpi_pkg::QUAD_1;
            r = {1'b0, a} - 10'(hlpi_pkg::QUARTER);
        end
        else
        begin
            q = hlpi_pkg::QUAD_0;
            r = {1'b0, a};
        end
        e = hlpi_pkg::TRIG_ROM[r[hlpi_pkg::TRIG_AW-1:0]];
        s = $signed({1'b0, e[2*hlpi_pkg::TRIG_MAG_W-1:hlpi_pkg::TRIG_MAG_W]});
        c = $signed({1'b0, e[hlpi_pkg::TRIG_MAG_W-1:0]});
        case (q)
            hlpi_pkg::QUAD_0:
            begin
                so = s;
                co = c;
            end
            hlpi_pkg::QUAD_1:
            begin
                so = c;
                co = -s;
            end
            hlpi_pkg::QUAD_2:
            begin
                so = -s;
                co = -c;
            end
            default:
            begin
                so = -c;
                co = s;
            end
        endcase
        return {so, co};
    endfunction

    logic                                v1_reg;
    logic signed [hlpi_pkg::TRIG_W-1:0]  s1_reg, c1_reg, s2_reg, c2_reg;
    logic signed [hlpi_pkg::RHO_W-1:0]   r1a_reg, r2a_reg;

    always_ff @(posedge clk)
    begin
        {s1_reg, c1_reg} <= trig_lookup(request.first_angle);
        {s2_reg, c2_reg} <= trig_lookup(request.second_angle);
        r1a_reg          <= request.first_rho;
        r2a_reg          <= request.second_rho;
    end

    // ---------------- stage 2: products ----------------
    logic                                v2_reg;
    logic signed [hlpi_pkg::PROD_W-1:0]  c1s2_reg, s1c2_reg;
    logic signed [hlpi_pkg::PROD_W-1:0]  r1s2_reg, r2s1_reg, r2c1_reg, r1c2_reg;

    always_ff @(posedge clk)
    begin
        c1s2_reg <= c1_reg * s2_reg;
        s1c2_reg <= s1_reg * c2_reg;
        r1s2_reg <= r1a_reg * s2_reg;
        r2s1_reg <= r2a_reg * s1_reg;
        r2c1_reg <= r2a_reg * c1_reg;
        r1c2_reg <= r1a_reg * c2_reg;
    end

    // ---------------- stage 3: differences ----------------
    logic                                v3_reg;
    logic signed [hlpi_pkg::PROD_W-1:0]  det_reg, nx_reg, ny_reg;

    always_ff @(posedge clk)
    begin
        det_reg <= c1s2_reg - s1c2_reg;
        nx_reg  <= r1s2_reg - r2s1_reg;
        ny_reg  <= r2c1_reg - r1c2_reg;
    end

    // ---------------- stage 4: magnitudes and threshold ----------------
    logic                          v4_reg;
    logic                          ok4_reg, negx4_reg, negy4_reg;
    logic [hlpi_pkg::MAG_W-1:0]    ad4_reg, anx4_reg, any4_reg;
    logic [hlpi_pkg::PROD_W-1:0]   ad_full, anx_full, any_full;

    assign ad_full  = det_reg[hlpi_pkg::PROD_W-1] ? -det_reg : det_reg;
    assign anx_full = nx_reg[hlpi_pkg::PROD_W-1]  ? -nx_reg  : nx_reg;
    assign any_full = ny_reg[hlpi_pkg::PROD_W-1]  ? -ny_reg  : ny_reg;

    always_ff @(posedge clk)
    begin
        ad4_reg   <= ad_full[hlpi_pkg::MAG_W-1:0];
        anx4_reg  <= anx_full[hlpi_pkg::MAG_W-1:0];
        any4_reg  <= any_full[hlpi_pkg::MAG_W-1:0];
        negx4_reg <= nx_reg[hlpi_pkg::PROD_W-1] ^ det_reg[hlpi_pkg::PROD_W-1];
        negy4_reg <= ny_reg[hlpi_pkg::PROD_W-1] ^ det_reg[hlpi_pkg::PROD_W-1];
        ok4_reg   <= (det_reg != '0) && (ad_full[hlpi_pkg::MAG_W-1:0] >= thr_reg);
    end

    // ---------------- stage 5: dividend set-up ----------------
    logic [hlpi_pkg::NUM_W-1:0] numx, numy;

    assign numx = {1'b0, anx4_reg, 15'd0} + NUM_W'(ad4_reg >> 1);
    assign numy = {1'b0, any4_reg, 15'd0} + NUM_W'(ad4_reg >> 1);

    // Divider stage arrays: index 0 is loaded from stage 5
    logic                          dv_reg   [NST+1];
    logic                          ok_reg   [NST+1];
    logic                          negx_reg [NST+1];
    logic                          negy_reg [NST+1];
    logic                          ovfx_reg [NST+1];
    logic                          ovfy_reg [NST+1];
    logic [hlpi_pkg::MAG_W-1:0]    ad_reg   [NST+1];
    logic [hlpi_pkg::MAG_W-1:0]    remx_reg [NST+1];
    logic [hlpi_pkg::MAG_W-1:0]    remy_reg [NST+1];
    logic [NST-1:0]                lowx_reg [NST+1];
    logic [NST-1:0]                lowy_reg [NST+1];
    logic [NST-1:0]                qx_reg   [NST+1];
    logic [NST-1:0]                qy_reg   [NST+1];

    // ---------------- divider: one quotient bit per stage ----------------
    logic [hlpi_pkg::MAG_W:0] tx [NST];
    logic [hlpi_pkg::MAG_W:0] ty [NST];
    logic [hlpi_pkg::MAG_W:0] dx [NST];
    logic [hlpi_pkg::MAG_W:0] dy [NST];

    always_comb
    begin
        for (int d = 0; d < NST; d++)
        begin
            tx[d] = {remx_reg[d], lowx_reg[d][NST-1]};
            ty[d] = {remy_reg[d], lowy_reg[d][NST-1]};
            dx[d] = tx[d] - {1'b0, ad_reg[d]};
            dy[d] = ty[d] - {1'b0, ad_reg[d]};
        end
    end

    always_ff @(posedge clk)
    begin
        // load the first stage from the dividend set-up
        ok_reg[0]   <= ok4_reg;
        negx_reg[0] <= negx4_reg;
        negy_reg[0] <= negy4_reg;
        ad_reg[0]   <= ad4_reg;
        ovfx_reg[0] <= {{(hlpi_pkg::MAG_W-HI_W){1'b0}}, numx[NUM_W-1:NST]} >= ad4_reg;
        ovfy_reg[0] <= {{(hlpi_pkg::MAG_W-HI_W){1'b0}}, numy[NUM_W-1:NST]} >= ad4_reg;
        remx_reg[0] <= {{(hlpi_pkg::MAG_W-HI_W){1'b0}}, numx[NUM_W-1:NST]};
        remy_reg[0] <= {{(hlpi_pkg::MAG_W-HI_W){1'b0}}, numy[NUM_W-1:NST]};
        lowx_reg[0] <= numx[NST-1:0];
        lowy_reg[0] <= numy[NST-1:0];
        qx_reg[0]   <= '0;
        qy_reg[0]   <= '0;
        for (int d = 0; d < NST; d++)
        begin
            ok_reg[d+1]   <= ok_reg[d];
            negx_reg[d+1] <= negx_reg[d];
            negy_reg[d+1] <= negy_reg[d];
            ovfx_reg[d+1] <= ovfx_reg[d];
            ovfy_reg[d+1] <= ovfy_reg[d];
            ad_reg[d+1]   <= ad_reg[d];
            lowx_reg[d+1] <= {lowx_reg[d][NST-2:0], 1'b0};
            lowy_reg[d+1] <= {lowy_reg[d][NST-2:0], 1'b0};
            // subtract when the partial remainder covers the divisor
            if (tx[d] >= {1'b0, ad_reg[d]})
            begin
                remx_reg[d+1] <= dx[d][hlpi_pkg::MAG_W-1:0];
                qx_reg[d+1]   <= {qx_reg[d][NST-2:0], 1'b1};
            end
            else
            begin
                remx_reg[d+1] <= tx[d][hlpi_pkg::MAG_W-1:0];
                qx_reg[d+1]   <= {qx_reg[d][NST-2:0], 1'b0};
            end
            if (ty[d] >= {1'b0, ad_reg[d]})
            begin
                remy_reg[d+1] <= dy[d][hlpi_pkg::MAG_W-1:0];
                qy_reg[d+1]   <= {qy_reg[d][NST-2:0], 1'b1};
            end
            else
            begin
                remy_reg[d+1] <= ty[d][hlpi_pkg::MAG_W-1:0];
                qy_reg[d+1]   <= {qy_reg[d][NST-2:0], 1'b0};
            end
        end
    end

    // ---------------- valid bits through every stage ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            for (int d = 0; d <= NST; d++)
            begin
                dv_reg[d] <= 1'b0;
            end
        end
        else
        begin
            v1_reg    <= start;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
            dv_reg[0] <= v4_reg;
            for (int d = 0; d < NST; d++)
            begin
                dv_reg[d+1] <= dv_reg[d];
            end
        end
    end

    // ---------------- output: sign, saturate, drop parallel pairs ----------------
    function automatic logic signed [hlpi_pkg::OUT_W-1:0] sat_sign(
        logic neg, logic ovf, logic [NST-1:0] q);
        logic signed [hlpi_pkg::OUT_W-1:0] v;
        if (neg)
        begin
            if (ovf || (q > NST'(8388608)))
                v = hlpi_pkg::OUT_MIN;
            else
                v = -$signed(q);
        end
        else
        begin
            if (ovf || (q > NST'(8388607)))
                v = hlpi_pkg::OUT_MAX;
            else
                v = $signed(q);
        end
        return v;
    endfunction

    logic           done_reg;
    hlpi_pkg::res_t result_reg;
    hlpi_pkg::res_t result_next;

    always_comb
    begin
        result_next.valid_res = ok_reg[NST];
        result_next.point_x   = '0;
        result_next.point_y   = '0;
        if (ok_reg[NST])
        begin
            result_next.point_x = sat_sign(negx_reg[NST], ovfx_reg[NST], qx_reg[NST]);
            result_next.point_y = sat_sign(negy_reg[NST], ovfy_reg[NST], qy_reg[NST]);
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dv_reg[NST];
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
